### hdl/apdu_pkg.sv
// Package with the constants and types of the APDU notification fragmenter.
package apdu_pkg;

  // Largest APDU that is framed; longer messages are refused.
  localparam int unsigned MAX_APDU_BYTES = 1024;

  // Header bytes of every notification frame.
  localparam logic [7:0] CHAN_BYTE = 8'h01;
  localparam logic [7:0] TAG_APDU  = 8'h05;

  // Smallest frame size and the reset value of the frame size register.
  localparam logic [9:0] MIN_CHUNK   = 10'd8;
  localparam logic [9:0] CHUNK_RESET = 10'd20;

  // Header lengths: the first frame of a message also carries the length.
  localparam logic [2:0] HDR_NONE  = 3'd0;
  localparam logic [2:0] HDR_NEXT  = 3'd5;
  localparam logic [2:0] HDR_FIRST = 3'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_LEN     = 2'd1,
    ST_SMALL_CHUNK = 2'd2
  } status_t;

  // Everything needed to emit the results of one accepted item.
  typedef struct packed {
    logic [2:0]  hdr_cnt;   // header bytes to send before the payload byte
    logic [15:0] seq;       // sequence number of the frame being opened
    logic [15:0] len;       // message length for the first frame header
    logic [7:0]  data;      // payload byte, zero on an error result
    logic        frame_end;
    logic        msg_end;
    status_t     status;
  } job_t;

endpackage

### hdl/apdu_notification_fragmenter.sv
// Top level of the APDU notification fragmenter: framing logic and result sequencer.
//
// Each accepted item is one APDU byte with the message length beside it. It
// is framed in the cycle it is accepted: the message counters are updated
// and a job holding the header and the payload byte is registered. A
// sequencer then moves one result a cycle, while the output register is free
// or being read, from the job into the output register. An item gives one
// result in an open frame, six when it opens a later frame (five header
// bytes) and eight when it opens the first frame (seven header bytes). Error
// items give one result. The next item is accepted in the cycle the last
// result of the current job moves to the output register, and the output
// register lets the input side continue while a result waits to be taken.
// The frame size register may be written only while the block is idle.
module apdu_notification_fragmenter (
  input  logic        clk,
  input  logic        rst_n,
  // Frame size register
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,   // chunk_size
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [7:0] data_byte, [23:8] message_length
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [7:0] out_byte
  output logic        out_tlast,     // last_of_run
  output logic [3:0]  out_tuser      // [0] frame_end, [1] message_end, [3:2] status
);

  logic [9:0]  chunk_r;
  logic [15:0] bytes_sent_r, bytes_sent_nxt;
  logic [15:0] latched_r, latched_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [9:0]  fill_r, fill_nxt;

  apdu_pkg::job_t job_r, job_nxt;
  logic           job_valid_r;
  logic [2:0]     idx_r;

  logic [7:0] out_byte_r;
  logic       out_fe_r, out_me_r, out_last_r;
  apdu_pkg::status_t out_st_r;
  logic       out_valid_r;

  logic in_acc, out_load, job_done;

  // Handshake between the stages
  assign out_load  = job_valid_r && (!out_valid_r || out_tready);
  assign job_done  = out_load && (idx_r == job_r.hdr_cnt);
  assign in_tready = !job_valid_r || job_done;
  assign in_acc    = in_tvalid && in_tready;

  // Framing of one incoming byte against the message state
  always_comb begin
    logic        start;
    logic [15:0] len;
    logic [15:0] seq;
    logic [9:0]  fill;
    logic [15:0] cnt;
    logic        done;
    logic [2:0]  hdr;
    logic [9:0]  fill_inc;
    logic        fe;

    start    = (bytes_sent_r == 16'd0);
    len      = start ? in_tdata[23:8] : latched_r;
    seq      = start ? 16'd0 : seq_r;
    fill     = start ? 10'd0 : fill_r;
    cnt      = bytes_sent_r + 16'd1;
    done     = (cnt == len);
    hdr      = (fill == 10'd0) ? ((seq == 16'd0) ? apdu_pkg::HDR_FIRST : apdu_pkg::HDR_NEXT)
                               : apdu_pkg::HDR_NONE;
    fill_inc = fill + {7'd0, hdr} + 10'd1;
    fe       = (fill_inc >= chunk_r) || done;

    latched_nxt    = len;
    seq_nxt        = seq;
    fill_nxt       = fill;
    bytes_sent_nxt = bytes_sent_r;

    job_nxt.hdr_cnt   = apdu_pkg::HDR_NONE;
    job_nxt.seq       = seq;
    job_nxt.len       = len;
    job_nxt.data      = 8'd0;
    job_nxt.frame_end = 1'b0;
    job_nxt.msg_end   = 1'b0;
    job_nxt.status    = apdu_pkg::ST_BAD_LEN;

    if (len != 16'd0) begin
      bytes_sent_nxt = done ? 16'd0 : cnt;
      if (len > 16'(apdu_pkg::MAX_APDU_BYTES)) begin
        job_nxt.status = apdu_pkg::ST_BAD_LEN;
      end else if (chunk_r < apdu_pkg::MIN_CHUNK) begin
        job_nxt.status = apdu_pkg::ST_SMALL_CHUNK;
      end else begin
        job_nxt.hdr_cnt   = hdr;
        job_nxt.data      = in_tdata[7:0];
        job_nxt.frame_end = fe;
        job_nxt.msg_end   = done;
        job_nxt.status    = apdu_pkg::ST_OK;
        fill_nxt          = fe ? 10'd0 : fill_inc;
        seq_nxt           = fe ? seq + 16'd1 : seq;
      end
    end
  end

  // Frame size register and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r      <= apdu_pkg::CHUNK_RESET;
      bytes_sent_r <= 16'd0;
      latched_r    <= 16'd0;
      seq_r        <= 16'd0;
      fill_r       <= 10'd0;
    end else begin
      if (cfg_wr_en) begin
        chunk_r <= cfg_wr_data;
      end
      if (in_acc) begin
        bytes_sent_r <= bytes_sent_nxt;
        latched_r    <= latched_nxt;
        seq_r        <= seq_nxt;
        fill_r       <= fill_nxt;
      end
    end
  end

  // Job register and the result index within it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (in_acc) begin
        job_valid_r <= 1'b1;
        idx_r       <= 3'd0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
        idx_r       <= 3'd0;
      end else if (out_load) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_r <= job_nxt;
    end
  end

  // Header bytes in sending order; the payload byte comes from the job
  logic [7:0] hdr_bytes [8];
  always_comb begin
    hdr_bytes[0] = apdu_pkg::CHAN_BYTE;
    hdr_bytes[1] = apdu_pkg::CHAN_BYTE;
    hdr_bytes[2] = apdu_pkg::TAG_APDU;
    hdr_bytes[3] = job_r.seq[15:8];
    hdr_bytes[4] = job_r.seq[7:0];
    hdr_bytes[5] = job_r.len[15:8];
    hdr_bytes[6] = job_r.len[7:0];
    hdr_bytes[7] = 8'd0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (idx_r == job_r.hdr_cnt) begin
        out_byte_r <= job_r.data;
        out_fe_r   <= job_r.frame_end;
        out_me_r   <= job_r.msg_end;
        out_last_r <= 1'b1;
        out_st_r   <= job_r.status;
      end else begin
        out_byte_r <= hdr_bytes[idx_r];
        out_fe_r   <= 1'b0;
        out_me_r   <= 1'b0;
        out_last_r <= 1'b0;
        out_st_r   <= apdu_pkg::ST_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_st_r, out_me_r, out_fe_r};

  // The sequencer never runs past the payload byte of its job
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r <= job_r.hdr_cnt)
    else $error("result index beyond the job");

  // A job carries no header, a short header or the full first header
  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (job_r.hdr_cnt == apdu_pkg::HDR_NONE ||
                     job_r.hdr_cnt == apdu_pkg::HDR_NEXT ||
                     job_r.hdr_cnt == apdu_pkg::HDR_FIRST))
    else $error("bad header length in job");

  // An error result is a lone, empty item
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != apdu_pkg::ST_OK) |->
      (out_last_r && out_byte_r == 8'd0 && !out_fe_r && !out_me_r))
    else $error("error result carries data");

  // The end of a message always closes its frame, on the item's last result
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_me_r) |-> (out_fe_r && out_last_r))
    else $error("message end without frame end");

endmodule

### sim/apdu_notification_fragmenter_tb.sv
// Self-checking testbench for the APDU notification fragmenter: predicts framed bytes per item.
`timescale 1ns / 1ps

module apdu_notification_fragmenter_tb;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // One framed byte as it should leave the block.
  typedef struct packed {
    logic [7:0]         byte_val;
    logic               frame_end;
    logic               msg_end;
    logic               run_last;
    apdu_pkg::status_t  status;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = 10'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;     // [7:0] data_byte, [23:8] message_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] out_byte
  logic        out_tlast;            // last_of_run
  logic [3:0]  out_tuser;            // [0] frame_end, [1] message_end, [3:2] status

  // Framer state mirrored by the predictor.
  logic [9:0]  chunk_bytes = apdu_pkg::CHUNK_RESET;
  logic [15:0] msg_taken = 16'd0;
  logic [15:0] msg_len = 16'd0;
  logic [15:0] frame_seq = 16'd0;
  logic [9:0]  frame_fill = 10'd0;

  framed_byte_t  frames_due[$];
  logic [23:0]   apdu_bytes_pending[$];
  framed_byte_t  due;
  int unsigned   items_queued = 0;
  int unsigned   items_accepted = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_wait = 0;
  int unsigned   recv_wait = 0;
  bit            send_idle = 1'b1;
  bit            recv_idle = 1'b1;
  logic          send_next;
  logic          hold_off = 1'b0;

  apdu_notification_fragmenter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned pause_cycles(input bit idle_on);
    return idle_on ? $urandom_range(0, 19) : 0;
  endfunction

  task automatic expect_byte(input logic [7:0] v, input logic fe, input logic me,
                             input logic lst, input apdu_pkg::status_t st);
    frames_due.push_back({v, fe, me, lst, st});
  endtask

  // Works out the framed bytes that one accepted APDU byte gives.
  task automatic frame_apdu_byte(input logic [7:0] b, input logic [15:0] len_in);
    logic done;
    logic fe;
    if (msg_taken == 16'd0) begin
      msg_len    = len_in;
      frame_seq  = 16'd0;
      frame_fill = 10'd0;
    end
    // A zero-length byte is a message of its own and counts for nothing.
    if (msg_len == 16'd0) begin
      expect_byte(8'h00, 1'b0, 1'b0, 1'b1, apdu_pkg::ST_BAD_LEN);
      return;
    end
    msg_taken = msg_taken + 16'd1;
    done = (msg_taken == msg_len);
    if (done) begin
      msg_taken = 16'd0;
    end
    // Refused bytes still count toward the message length.
    if (msg_len > 16'(apdu_pkg::MAX_APDU_BYTES)) begin
      expect_byte(8'h00, 1'b0, 1'b0, 1'b1, apdu_pkg::ST_BAD_LEN);
      return;
    end
    if (chunk_bytes < apdu_pkg::MIN_CHUNK) begin
      expect_byte(8'h00, 1'b0, 1'b0, 1'b1, apdu_pkg::ST_SMALL_CHUNK);
      return;
    end
    // Open a frame: channel, tag and sequence, plus the length on the first frame.
    if (frame_fill == 10'd0) begin
      expect_byte(apdu_pkg::CHAN_BYTE, 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
      expect_byte(apdu_pkg::CHAN_BYTE, 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
      expect_byte(apdu_pkg::TAG_APDU, 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
      expect_byte(frame_seq[15:8], 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
      expect_byte(frame_seq[7:0], 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
      frame_fill = {7'd0, apdu_pkg::HDR_NEXT};
      if (frame_seq == 16'd0) begin
        expect_byte(msg_len[15:8], 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
        expect_byte(msg_len[7:0], 1'b0, 1'b0, 1'b0, apdu_pkg::ST_OK);
        frame_fill = {7'd0, apdu_pkg::HDR_FIRST};
      end
    end
    frame_fill = frame_fill + 10'd1;
    fe = (frame_fill >= chunk_bytes) || done;
    expect_byte(b, fe, done, 1'b1, apdu_pkg::ST_OK);
    if (fe) begin
      frame_fill = 10'd0;
      frame_seq  = frame_seq + 16'd1;
    end
  endtask

  // Driver: offers pending items, with a random pause after each accepted one when send idling is on.
  always @(posedge clk) begin
    if (rst_n) begin
      send_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        frame_apdu_byte(in_tdata[7:0], in_tdata[23:8]);
        items_accepted++;
        send_next = 1'b0;
        send_wait = pause_cycles(send_idle);
      end
      if (!send_next) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (apdu_bytes_pending.size() != 0) begin
          in_tdata <= apdu_bytes_pending.pop_front();
          send_next = 1'b1;
        end
      end
      in_tvalid <= send_next;
    end
  end

  // Monitor: checks each accepted result against the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: byte %02h tuser %04b tlast %0b",
                     out_tdata, out_tuser, out_tlast);
          end
        end else begin
          due = frames_due.pop_front();
          if (out_tdata !== due.byte_val || out_tuser[0] !== due.frame_end ||
              out_tuser[1] !== due.msg_end || out_tlast !== due.run_last ||
              out_tuser[3:2] !== due.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: expected byte %02h fe %0b me %0b last %0b st %0d",
                       due.byte_val, due.frame_end, due.msg_end, due.run_last, due.status);
              $display("          got      byte %02h fe %0b me %0b last %0b st %0d",
                       out_tdata, out_tuser[0], out_tuser[1], out_tlast, out_tuser[3:2]);
            end
          end
        end
        recv_wait = pause_cycles(recv_idle);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0) && !hold_off;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  initial begin
    wait (items_accepted >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic [15:0] len);
    apdu_bytes_pending.push_back({len, b});
    items_queued++;
  endtask

  // A whole message: the length on its first byte, random values on the rest.
  task automatic queue_message(input int unsigned n, input logic [15:0] len);
    int unsigned k;
    queue_byte(8'($urandom_range(0, 255)), len);
    for (k = 1; k < n; k++) begin
      queue_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (items_accepted != items_queued || frames_due.size() != 0);
  endtask

  task automatic write_chunk(input logic [9:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chunk_bytes = value;
  endtask

  // Random messages under one frame size, with zero-length bytes as noise.
  // The last message of a phase is cut short so that the phase queues exactly its target.
  task automatic run_phase(input logic [9:0] chunk, input int unsigned target,
                           input bit s_idle, input bit r_idle);
    int unsigned start;
    int unsigned pick;
    int unsigned room;
    start = items_queued;
    send_idle = s_idle;
    recv_idle = r_idle;
    write_chunk(chunk);
    while (items_queued - start < target) begin
      room = target - (items_queued - start);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_byte(8'($urandom_range(0, 255)), 16'd0);
      end else begin
        if (pick < 85) begin
          pick = $urandom_range(1, 20);
        end else begin
          pick = $urandom_range(21, 70);
        end
        if (pick > room) begin
          pick = room;
        end
        queue_message(pick, pick[15:0]);
      end
    end
    wait_drained();
  endtask

  initial begin
    int unsigned n;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed: single-byte message, zero-length bytes, a short message.
    queue_byte(8'hFF, 16'd1);
    queue_byte(8'h00, 16'd0);
    queue_byte(8'hA5, 16'd0);
    queue_message(3, 16'd3);
    wait_drained();

    // Smallest frame size: frames close on fill.
    write_chunk(apdu_pkg::MIN_CHUNK);
    queue_message(5, 16'd5);
    wait_drained();

    // Frame size changed mid frame, then too small, then 514.
    write_chunk(apdu_pkg::CHUNK_RESET);
    queue_byte(8'($urandom_range(0, 255)), 16'd6);
    queue_byte(8'($urandom_range(0, 255)), 16'hFFFF);
    queue_byte(8'($urandom_range(0, 255)), 16'h0000);
    wait_drained();
    write_chunk(10'd9);
    queue_byte(8'($urandom_range(0, 255)), 16'd6);
    wait_drained();
    write_chunk(10'd7);
    queue_byte(8'($urandom_range(0, 255)), 16'd6);
    wait_drained();
    write_chunk(10'd0);
    queue_byte(8'($urandom_range(0, 255)), 16'd6);
    wait_drained();
    write_chunk(10'd514);
    queue_message(4, 16'd4);
    wait_drained();

    // Random phases over several frame sizes and idling patterns.
    run_phase(10'd8, 42, 1'b0, 1'($urandom_range(0, 1)));
    run_phase(10'd514, 42, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_phase(10'($urandom_range(8, 40)), 42, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    run_phase(10'($urandom_range(0, 7)), 12, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    run_phase(10'($urandom_range(10, 30)), 42, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    run_phase(10'd13, 42, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

    // An over-long message to close: every byte is refused.
    write_chunk(10'($urandom_range(8, 30)));
    n = $urandom_range(1025, 65535);
    queue_message(20, n[15:0]);
    wait_drained();
    repeat (16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hdl/apdu_pkg.sv
hdl/apdu_notification_fragmenter.sv
sim/apdu_notification_fragmenter_tb.sv
